// ===== rtl/core/frm_pkg.sv =====
// Shared widths and constants for the frame interval rate meter.
`default_nettype none

package frm_pkg;

   // Number of accepted intervals kept in the averaging window.
   localparam int WINDOW_DEPTH = 64;
   localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
   localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);

   // Fixed field widths.
   localparam int TICK_W = 32;
   localparam int RATE_W = 16;
   localparam int ACC_W  = TICK_W + 1;
   localparam int SUM_W  = TICK_W + $clog2(WINDOW_DEPTH);

   // Serial divider step counter.
   localparam int DIV_CNT_W = $clog2(SUM_W);

   localparam logic [TICK_W-1:0] TICKS_PER_SECOND_RESET = TICK_W'(1000);

endpackage : frm_pkg

`default_nettype wire

// ===== rtl/core/frm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module frm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : frm_ram

`default_nettype wire

// ===== rtl/core/frame_interval_rate_meter.sv =====
// Frame interval rate meter: windowed mean frame interval and frames-per-second count.
//
// Each req transaction carries a free-running counter stamp taken at one frame. The
// block measures the interval since the previous stamp (mod 2^32), drops it when it
// differs from the current mean by ticks_per_second or more, and otherwise writes it
// into a 64-entry window RAM while a running sum tracks the window contents. One rsp
// transaction per req gives the new mean interval, the frame count of the last
// completed second and whether the sample entered the window. The block works on one
// transaction at a time: an accepted stamp passes the calc, update, divide and done
// states in that order, the restoring divider producing one quotient bit per cycle for
// window_sum / samples_held, and the next stamp is accepted once the block is back in
// idle. A waiting result sits in the output register and does not hold off the next
// stamp's arithmetic, only its own handoff. The window RAM needs no clearing pass after
// reset; entries read back are only used once the window is full. Write ticks_per_second
// through the csr channel only while no transaction is in flight; it resets to 1000.
`default_nettype none

module frame_interval_rate_meter
   import frm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [TICK_W-1:0] req_time_stamp,

   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [TICK_W-1:0] rsp_smoothed_interval,
   output logic      [RATE_W-1:0] rsp_frame_rate,
   output logic                   rsp_sample_taken,

   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [TICK_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_UPDATE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;

   logic [TICK_W-1:0]     tps_ff, tps_in;
   logic [TICK_W-1:0]     last_stamp_ff, last_stamp_in;
   logic [TICK_W-1:0]     interval_ff, interval_in;
   logic                  taken_ff, taken_in;
   logic [SLOT_W-1:0]     write_slot_ff, write_slot_in;
   logic [COUNT_W-1:0]    samples_held_ff, samples_held_in;
   logic [SUM_W-1:0]      window_sum_ff, window_sum_in;
   logic [TICK_W-1:0]     mean_ff, mean_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [RATE_W-1:0]     frames_ff, frames_in;
   logic [RATE_W-1:0]     latched_rate_ff, latched_rate_in;

   logic [SUM_W-1:0]      quot_ff, quot_in;
   logic [COUNT_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TICK_W-1:0]     rsp_interval_ff, rsp_interval_in;
   logic [RATE_W-1:0]     rsp_rate_ff, rsp_rate_in;
   logic                  rsp_taken_ff, rsp_taken_in;

   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [TICK_W-1:0]     ram_rd_data;

   logic                  window_full;
   logic [TICK_W-1:0]     diff;
   logic [ACC_W-1:0]      acc_sum;
   logic [RATE_W-1:0]     frames_inc;
   logic [COUNT_W:0]      trial;
   logic [COUNT_W:0]      trial_sub;
   logic                  qbit;
   logic [TICK_W-1:0]     mean_result;

   frm_ram #(
      .WIDTH (TICK_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (write_slot_ff),
      .wr_data (interval_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (write_slot_ff),
      .rd_data (ram_rd_data)
   );

   assign window_full = (samples_held_ff == COUNT_W'(WINDOW_DEPTH));
   assign diff        = (interval_ff >= mean_ff) ? (interval_ff - mean_ff)
                                                 : (mean_ff - interval_ff);
   assign acc_sum     = acc_ff + ACC_W'(mean_ff);
   assign frames_inc  = (frames_ff == '1) ? frames_ff : frames_ff + RATE_W'(1);

   // Restoring divide step: shift the next dividend bit into the remainder.
   assign trial       = {rem_ff, quot_ff[SUM_W-1]};
   assign trial_sub   = trial - {1'b0, samples_held_ff};
   assign qbit        = (trial >= {1'b0, samples_held_ff});
   assign mean_result = (samples_held_ff == '0) ? '0 : quot_ff[TICK_W-1:0];

   always_comb begin
      state_in        = state_ff;
      tps_in          = tps_ff;
      last_stamp_in   = last_stamp_ff;
      interval_in     = interval_ff;
      taken_in        = taken_ff;
      write_slot_in   = write_slot_ff;
      samples_held_in = samples_held_ff;
      window_sum_in   = window_sum_ff;
      mean_in         = mean_ff;
      acc_in          = acc_ff;
      frames_in       = frames_ff;
      latched_rate_in = latched_rate_ff;
      quot_in         = quot_ff;
      rem_in          = rem_ff;
      div_cnt_in      = div_cnt_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_interval_in = rsp_interval_ff;
      rsp_rate_in     = rsp_rate_ff;
      rsp_taken_in    = rsp_taken_ff;
      req_ready       = 1'b0;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;

      if (csr_valid) begin
         tps_in = csr_data;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               interval_in   = req_time_stamp - last_stamp_ff;
               last_stamp_in = req_time_stamp;
               state_in      = ST_CALC;
            end
         end
         ST_CALC: begin
            taken_in  = (diff < tps_ff);
            // Fetch the oldest entry; it is used only when the window is full.
            ram_rd_en = 1'b1;
            if (acc_sum > ACC_W'(tps_ff)) begin
               latched_rate_in = frames_inc;
               frames_in       = '0;
               acc_in          = '0;
            end else begin
               frames_in       = frames_inc;
               acc_in          = acc_sum;
            end
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (taken_ff) begin
               ram_wr_en     = 1'b1;
               window_sum_in = window_sum_ff - (window_full ? SUM_W'(ram_rd_data) : '0)
                               + SUM_W'(interval_ff);
               if (!window_full) begin
                  samples_held_in = samples_held_ff + COUNT_W'(1);
               end
               write_slot_in = (write_slot_ff == SLOT_W'(WINDOW_DEPTH - 1))
                               ? '0 : write_slot_ff + SLOT_W'(1);
            end
            quot_in    = window_sum_in;
            rem_in     = '0;
            div_cnt_in = '0;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            quot_in    = {quot_ff[SUM_W-2:0], qbit};
            rem_in     = qbit ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               mean_in         = mean_result;
               rsp_valid_in    = 1'b1;
               rsp_interval_in = mean_result;
               rsp_rate_in     = latched_rate_ff;
               rsp_taken_in    = taken_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      interval_ff     <= interval_in;
      taken_ff        <= taken_in;
      quot_ff         <= quot_in;
      rem_ff          <= rem_in;
      div_cnt_ff      <= div_cnt_in;
      rsp_interval_ff <= rsp_interval_in;
      rsp_rate_ff     <= rsp_rate_in;
      rsp_taken_ff    <= rsp_taken_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         tps_ff          <= TICKS_PER_SECOND_RESET;
         last_stamp_ff   <= '0;
         write_slot_ff   <= '0;
         samples_held_ff <= '0;
         window_sum_ff   <= '0;
         mean_ff         <= '0;
         acc_ff          <= '0;
         frames_ff       <= '0;
         latched_rate_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         tps_ff          <= tps_in;
         last_stamp_ff   <= last_stamp_in;
         write_slot_ff   <= write_slot_in;
         samples_held_ff <= samples_held_in;
         window_sum_ff   <= window_sum_in;
         mean_ff         <= mean_in;
         acc_ff          <= acc_in;
         frames_ff       <= frames_in;
         latched_rate_ff <= latched_rate_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_smoothed_interval = rsp_interval_ff;
   assign rsp_frame_rate        = rsp_rate_ff;
   assign rsp_sample_taken      = rsp_taken_ff;

   a_samples_bounded: assert property (@(posedge clock) disable iff (reset)
      samples_held_ff <= COUNT_W'(WINDOW_DEPTH))
      else $error("window sample count exceeds window depth");

   a_accept_starts_calc: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CALC))
      else $error("accepted transaction did not start processing");

   a_sum_only_in_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_UPDATE) |=> $stable(window_sum_ff))
      else $error("window sum changed outside the update step");

   a_write_needs_taken: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (taken_ff && (state_ff == ST_UPDATE)))
      else $error("window written for a rejected interval");

endmodule : frame_interval_rate_meter

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the frame interval rate meter.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import frm_pkg::*;

   localparam int CYCLE_LIMIT     = 20_000_000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int REPORT_CAP      = 40;

   typedef struct packed {
      logic [TICK_W-1:0] interval;
      logic [RATE_W-1:0] rate;
      logic              taken;
   } meter_reading_type;

   logic              clock;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [TICK_W-1:0] req_time_stamp = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [TICK_W-1:0] rsp_smoothed_interval;
   logic [RATE_W-1:0] rsp_frame_rate;
   logic              rsp_sample_taken;
   logic              csr_valid      = 1'b0;
   logic              csr_ready;
   logic [TICK_W-1:0] csr_data       = '0;

   frame_interval_rate_meter i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_time_stamp        (req_time_stamp),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_smoothed_interval (rsp_smoothed_interval),
      .rsp_frame_rate        (rsp_frame_rate),
      .rsp_sample_taken      (rsp_sample_taken),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Shadow state of the meter, updated on every accepted transaction.
   logic [TICK_W-1:0]  model_ticks = TICKS_PER_SECOND_RESET;
   logic [TICK_W-1:0]  model_last_stamp = '0;
   logic [TICK_W-1:0]  model_window [WINDOW_DEPTH];
   logic [SLOT_W-1:0]  model_slot = '0;
   logic [COUNT_W-1:0] model_held = '0;
   logic [SUM_W-1:0]   model_sum = '0;
   logic [TICK_W-1:0]  model_mean = '0;
   logic [ACC_W-1:0]   model_seconds_acc = '0;
   logic [RATE_W-1:0]  model_frames = '0;
   logic [RATE_W-1:0]  model_rate = '0;

   meter_reading_type expected_readings [$];
   int                error_count = 0;
   int                stamps_sent = 0;
   int                readings_checked = 0;
   logic [TICK_W-1:0] last_sent_stamp = '0;
   bit                idle_enable = 1'b1;
   int                hold_off_requests = 0;
   int                hold_off_served = 0;
   int                hold_left = 0;
   int                cycle_count = 0;

   task automatic predict_meter_reading(input logic [TICK_W-1:0] stamp);
      logic [TICK_W-1:0] interval;
      logic [TICK_W-1:0] distance;
      meter_reading_type reading;
      interval = stamp - model_last_stamp;
      model_last_stamp = stamp;
      distance = (interval >= model_mean) ? interval - model_mean : model_mean - interval;
      reading.taken = (distance < model_ticks);
      if (reading.taken) begin
         // full window: retire the oldest sample from the sum
         if (model_held == COUNT_W'(WINDOW_DEPTH))
            model_sum = model_sum - SUM_W'(model_window[model_slot]);
         else
            model_held = model_held + COUNT_W'(1);
         model_window[model_slot] = interval;
         model_sum = model_sum + SUM_W'(interval);
         model_slot = (model_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                 : model_slot + SLOT_W'(1);
      end
      if (model_frames != '1)
         model_frames = model_frames + RATE_W'(1);
      model_seconds_acc = model_seconds_acc + ACC_W'(model_mean);
      if (model_seconds_acc > ACC_W'(model_ticks)) begin
         model_rate = model_frames;
         model_frames = '0;
         model_seconds_acc = '0;
      end
      model_mean = (model_held != '0) ? TICK_W'(model_sum / SUM_W'(model_held)) : '0;
      reading.interval = model_mean;
      reading.rate = model_rate;
      expected_readings.push_back(reading);
   endtask

   task automatic report_mismatch(input string what, input logic [TICK_W-1:0] want,
                                  input logic [TICK_W-1:0] got);
      if (error_count < REPORT_CAP)
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      error_count++;
   endtask

   // Predict on each accepted stamp, track register writes, check each result.
   always @(posedge clock) begin
      meter_reading_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            predict_meter_reading(req_time_stamp);
         if (csr_valid && csr_ready)
            model_ticks = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("unexpected transaction", '0, rsp_smoothed_interval);
            end else begin
               want = expected_readings.pop_front();
               readings_checked++;
               if (rsp_smoothed_interval !== want.interval)
                  report_mismatch("smoothed_interval", want.interval, rsp_smoothed_interval);
               if (rsp_frame_rate !== want.rate)
                  report_mismatch("frame_rate", TICK_W'(want.rate), TICK_W'(rsp_frame_rate));
               if (rsp_sample_taken !== want.taken)
                  report_mismatch("sample_taken", TICK_W'(want.taken),
                                  TICK_W'(rsp_sample_taken));
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_off_served != hold_off_requests) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_OFF_CYCLES;
         hold_off_served <= hold_off_served + 1;
      end else begin
         rsp_ready <= idle_enable ? ($urandom_range(0, 99) >= 31) : 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offer one stamp and hold it until it is accepted; valid stays high.
   task automatic send_stamp(input logic [TICK_W-1:0] stamp);
      if (idle_enable) begin
         while ($urandom_range(0, 99) < 31) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_time_stamp <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      stamps_sent++;
      last_sent_stamp = stamp;
   endtask

   task automatic send_interval(input logic [TICK_W-1:0] interval);
      send_stamp(last_sent_stamp + interval);
   endtask

   task automatic drain_readings();
      req_valid <= 1'b0;
      while (readings_checked != stamps_sent) @(posedge clock);
   endtask

   task automatic write_ticks_per_second(input logic [TICK_W-1:0] ticks);
      csr_valid <= 1'b1;
      csr_data <= ticks;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_edges();
      send_stamp(32'd0);            // first frame, measured from zero
      send_stamp(32'd999);          // one tick inside the threshold
      send_stamp(32'd2498);         // exactly one second from the mean: drop
      send_stamp(32'd3996);         // one tick inside again
      send_stamp(32'd3996);         // zero interval
      send_stamp(32'hFFFF_FFF0);    // far outlier
      send_stamp(32'h0000_0010);    // counter wrap
      repeat (12) send_interval(TICK_W'($urandom_range(200, 900)));
      drain_readings();
   endtask

   task automatic test_zero_ticks();
      write_ticks_per_second('0);
      repeat (5) send_interval(model_mean);
      drain_readings();
      write_ticks_per_second(32'd1);
      send_interval(model_mean);
      drain_readings();
      send_interval(model_mean + TICK_W'(1));
      send_interval(model_mean - TICK_W'(1));
      drain_readings();
   endtask

   task automatic test_max_ticks();
      write_ticks_per_second('1);
      repeat (8) send_interval(32'h8000_0000);
      // fill the window with the widest interval, then overwrite it
      repeat (70) send_interval('1);
      send_interval('0);
      send_interval(32'd1);
      drain_readings();
   endtask

   task automatic test_long_second();
      idle_enable = 1'b0;
      // send many short frames under the widest second, then narrow the second to one tick
      repeat (70) send_interval(32'd1);
      drain_readings();
      write_ticks_per_second(32'd1);
      repeat (3) send_interval(32'd1);
      drain_readings();
      idle_enable = 1'b1;
   endtask

   task automatic test_output_backpressure();
      idle_enable = 1'b0;
      hold_off_requests++;
      repeat (16) send_interval(TICK_W'($urandom_range(1, 2)));
      drain_readings();
      idle_enable = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [TICK_W-1:0] ticks;
      logic [TICK_W-1:0] nominal;
      logic [TICK_W-1:0] span;
      longint            offset;
      int                kind;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: ticks = 32'd1000;
            1: ticks = 32'd1;
            2: ticks = TICK_W'($urandom_range(2, 40));
            3: ticks = TICK_W'($urandom_range(41, 1 << 20));
            4: ticks = TICK_W'($urandom);
            default: ticks = '1;
         endcase
         idle_enable = (phase != 2);
         write_ticks_per_second(ticks);
         nominal = ticks / TICK_W'($urandom_range(1, 64)) + TICK_W'($urandom_range(0, 3));
         span = (ticks > 32'h3FFF_FFFF) ? 32'h3FFF_FFFF : ticks + ticks / 4;
         repeat (70) begin
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
               // jitter around the nominal frame interval, straddling the outlier limit
               offset = longint'($urandom_range(0, 2 * span)) - longint'(span);
               send_interval(TICK_W'(longint'(nominal) + offset));
            end else if (kind < 95) begin
               send_interval(TICK_W'($urandom));
            end else begin
               send_interval('0);
            end
         end
         drain_readings();
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_zero_ticks();
      test_max_ticks();
      test_long_second();
      test_output_backpressure();
      test_random_traffic();
      repeat (SUM_W + 8) @(posedge clock);
      if (error_count == 0 && expected_readings.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
